>>> hdl/sme_pkg.sv
// Shared types and constants of the stable matching engine.
`default_nettype none

package sme_pkg;

    localparam int TYPE_W   = 2;
    localparam int PERSON_W = 5;
    localparam int COUNT_W  = 6;

    localparam logic [COUNT_W-1:0] PAIR_COUNT_RST = 6'd32;

    localparam logic [TYPE_W-1:0] REQ_LOAD_PROP = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_LOAD_ACC  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_RUN       = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_POP  = 5'b00010,
        ST_PREF = 5'b00100,
        ST_RANK = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic                pref_we;
        logic                rank_we;
        logic [PERSON_W-1:0] person;
        logic [PERSON_W-1:0] rank_pos;
        logic [PERSON_W-1:0] partner;
    } list_wr_t;

    typedef struct packed {
        logic [PERSON_W-1:0] pref_prop;
        logic [PERSON_W-1:0] pref_pos;
        logic [PERSON_W-1:0] rank_acc;
        logic [PERSON_W-1:0] rank_new;
        logic [PERSON_W-1:0] rank_cur;
    } list_rd_t;

    typedef struct packed {
        logic [PERSON_W-1:0] pref_acc;
        logic [PERSON_W-1:0] rank_new;
        logic [PERSON_W-1:0] rank_cur;
    } list_rd_data_t;

endpackage

`default_nettype wire

>>> hdl/sme_if.sv
// Request and result channel interfaces of the stable matching engine.
`default_nettype none

interface sme_req_if
    import sme_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [TYPE_W-1:0]   req_type;
    logic [PERSON_W-1:0] person;
    logic [PERSON_W-1:0] rank_pos;
    logic [PERSON_W-1:0] partner;

    modport source (output valid, output req_type, output person, output rank_pos,
                    output partner, input ready);
    modport sink   (input valid, input req_type, input person, input rank_pos,
                    input partner, output ready);
endinterface

interface sme_res_if
    import sme_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PERSON_W-1:0] proposer;
    logic [PERSON_W-1:0] acceptor;
    logic                last_pair;

    modport source (output valid, output proposer, output acceptor, output last_pair,
                    input ready);
    modport sink   (input valid, input proposer, input acceptor, input last_pair,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/stable_matching_engine_unit.sv
// Load items are taken while idle; a run item then works through the free-proposer stack.
// Each proposal pops a proposer, reads its next preference and, if that acceptor is engaged,
// reads and compares the two ranks; the list memories have registered reads.
// The n pairs then leave one per cycle when the sink is ready; the next item is taken after.
// Reset clears the control state and sets pair_count to 32; list memories hold no value
// until loaded, and there is no clearing pass.
`default_nettype none

module stable_matching_engine_unit
    import sme_pkg::*;
#(
    parameter int MAX_PAIRS = 32
)(
    input  logic             clk,
    input  logic             rst_n,
    sme_req_if.sink          req,
    sme_res_if.source        res,
    input  logic             cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    localparam int CAP = (MAX_PAIRS < 32) ? MAX_PAIRS : 32;
    localparam int PW  = $clog2(CAP);
    localparam int TW  = $clog2(CAP + 1);

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  pair_count_reg, pair_count_next;
    logic [TW-1:0]       n_reg, n_next;
    logic [TW-1:0]       top_reg, top_next;
    logic [PW-1:0]       m_reg, m_next;
    logic [PW-1:0]       w_reg, w_next;
    logic [PW-1:0]       cur_reg, cur_next;
    logic [PW-1:0]       k_reg, k_next;
    logic                res_valid_reg, res_valid_next;
    logic [PERSON_W-1:0] res_prop_reg, res_acc_reg;
    logic                res_last_reg;

    logic [TW-1:0]       next_choice_reg [CAP];
    logic [PW-1:0]       acc_partner_reg [CAP];
    logic [PW-1:0]       prop_partner_reg [CAP];
    logic [PW-1:0]       stk_reg [CAP];
    logic [CAP-1:0]      acc_busy_reg;
    logic [CAP-1:0]      stk_written_reg;

    logic [TW-1:0]       n_cfg;
    logic [TW-1:0]       top_m1;
    logic [PW-1:0]       sidx;
    logic [PW-1:0]       stk_rd;
    logic [TW-1:0]       nc_m;
    logic [PW-1:0]       pref_widx;
    logic                req_acc;
    logic                in_range;
    logic                run_start;
    logic                nc_inc;
    logic                push_en;
    logic [PW-1:0]       push_val;
    logic                assign_en;
    logic [PW-1:0]       asg_w;
    logic                drop_en;
    logic                out_load;

    list_wr_t            wr;
    list_rd_t            rd_req;
    list_rd_data_t       rdat;

    sme_list_mem #(
        .MAX_PAIRS (MAX_PAIRS)
    ) u_list_mem (
        .clk  (clk),
        .wr   (wr),
        .rd   (rd_req),
        .rdat (rdat)
    );

    assign req.ready     = (state_reg == ST_IDLE);
    assign req_acc       = req.valid && req.ready;
    assign res.valid     = res_valid_reg;
    assign res.proposer  = res_prop_reg;
    assign res.acceptor  = res_acc_reg;
    assign res.last_pair = res_last_reg;

    assign in_range = (int'(req.person) < MAX_PAIRS) && (int'(req.rank_pos) < MAX_PAIRS)
                      && (int'(req.partner) < MAX_PAIRS);

    always_comb
    begin
        wr.pref_we  = req_acc && (req.req_type == REQ_LOAD_PROP) && in_range;
        wr.rank_we  = req_acc && (req.req_type == REQ_LOAD_ACC) && in_range;
        wr.person   = req.person;
        wr.rank_pos = req.rank_pos;
        wr.partner  = req.partner;
    end

    always_comb
    begin
        if (pair_count_reg == '0)
        begin
            n_cfg = TW'(1);
        end
        else if (int'(pair_count_reg) > CAP)
        begin
            n_cfg = TW'(CAP);
        end
        else
        begin
            n_cfg = TW'(pair_count_reg);
        end
    end

    assign pair_count_next = cfg_we ? cfg_wdata : pair_count_reg;

    assign top_m1    = top_reg - 1'b1;
    assign sidx      = top_m1[PW-1:0];
    assign stk_rd    = stk_written_reg[sidx] ? stk_reg[sidx] : sidx;
    assign nc_m      = next_choice_reg[stk_rd];
    assign pref_widx = rdat.pref_acc[PW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        top_next       = top_reg;
        m_next         = m_reg;
        w_next         = w_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        run_start      = 1'b0;
        nc_inc         = 1'b0;
        push_en        = 1'b0;
        push_val       = m_reg;
        assign_en      = 1'b0;
        asg_w          = pref_widx;
        drop_en        = 1'b0;
        out_load       = 1'b0;

        rd_req.pref_prop = PERSON_W'(stk_rd);
        rd_req.pref_pos  = PERSON_W'(nc_m);
        rd_req.rank_acc  = rdat.pref_acc;
        rd_req.rank_new  = PERSON_W'(m_reg);
        rd_req.rank_cur  = PERSON_W'(acc_partner_reg[pref_widx]);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req.req_type == REQ_RUN))
                begin
                    run_start  = 1'b1;
                    n_next     = n_cfg;
                    top_next   = n_cfg;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                if (top_reg == '0)
                begin
                    k_next     = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    top_next = top_m1;
                    if (int'(nc_m) < int'(n_reg))
                    begin
                        nc_inc     = 1'b1;
                        m_next     = stk_rd;
                        state_next = ST_PREF;
                    end
                end
            end
            ST_PREF:
            begin
                state_next = ST_POP;
                w_next     = pref_widx;
                cur_next   = acc_partner_reg[pref_widx];
                if (int'(rdat.pref_acc) >= int'(n_reg))
                begin
                    push_en  = 1'b1;
                    top_next = top_reg + 1'b1;
                end
                else if (!acc_busy_reg[pref_widx])
                begin
                    assign_en = 1'b1;
                end
                else
                begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK:
            begin
                state_next = ST_POP;
                push_en    = 1'b1;
                top_next   = top_reg + 1'b1;
                if (rdat.rank_new < rdat.rank_cur)
                begin
                    drop_en   = 1'b1;
                    push_val  = cur_reg;
                    assign_en = 1'b1;
                    asg_w     = w_reg;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    out_load = 1'b1;
                    if (int'(k_reg) == int'(n_reg) - 1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pair_count_reg <= PAIR_COUNT_RST;
            n_reg          <= TW'(CAP);
            top_reg        <= '0;
            k_reg          <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pair_count_reg <= pair_count_next;
            n_reg          <= n_next;
            top_reg        <= top_next;
            k_reg          <= k_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        w_reg   <= w_next;
        cur_reg <= cur_next;
        if (out_load)
        begin
            res_prop_reg <= PERSON_W'(k_reg);
            res_acc_reg  <= PERSON_W'(prop_partner_reg[k_reg]);
            res_last_reg <= (int'(k_reg) == int'(n_reg) - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_busy_reg    <= '0;
            stk_written_reg <= '0;
        end
        else if (run_start)
        begin
            acc_busy_reg    <= '0;
            stk_written_reg <= '0;
        end
        else
        begin
            if (assign_en)
            begin
                acc_busy_reg[asg_w] <= 1'b1;
            end
            if (push_en)
            begin
                stk_written_reg[top_reg[PW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_start)
        begin
            for (int i = 0; i < CAP; i++)
            begin
                next_choice_reg[i]  <= '0;
                prop_partner_reg[i] <= '0;
            end
        end
        else
        begin
            if (nc_inc)
            begin
                next_choice_reg[stk_rd] <= nc_m + 1'b1;
            end
            if (push_en)
            begin
                stk_reg[top_reg[PW-1:0]] <= push_val;
            end
            if (assign_en)
            begin
                acc_partner_reg[asg_w] <= m_reg;
                prop_partner_reg[m_reg] <= asg_w;
            end
            if (drop_en)
            begin
                prop_partner_reg[cur_reg] <= '0;
            end
        end
    end

    a_top_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= n_reg)
        else $error("free stack holds more entries than active pairs");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> (top_reg < n_reg))
        else $error("push onto a full free stack");

    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req.req_type == REQ_RUN)) |=> (state_reg == ST_POP))
        else $error("run item did not start the proposal loop");

    a_rank_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RANK) |-> acc_busy_reg[w_reg])
        else $error("rank compare against a free acceptor");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (int'(k_reg) == int'(n_reg) - 1)) |=> (state_reg == ST_IDLE))
        else $error("result stream did not end after the last pair");

endmodule

`default_nettype wire

>>> hdl/sme_list_mem.sv
// Preference and rank memories with one write port and registered reads.
`default_nettype none

module sme_list_mem
    import sme_pkg::*;
#(
    parameter int MAX_PAIRS = 32
)(
    input  logic          clk,
    input  list_wr_t      wr,
    input  list_rd_t      rd,
    output list_rd_data_t rdat
);

    localparam int DEPTH = MAX_PAIRS * MAX_PAIRS;
    localparam int AW    = $clog2(DEPTH);

    logic [PERSON_W-1:0] pref_mem [DEPTH];
    logic [PERSON_W-1:0] rank_mem [DEPTH];
    list_rd_data_t       rdat_reg;

    function automatic logic [AW-1:0] flat_addr(input logic [PERSON_W-1:0] row,
                                                 input logic [PERSON_W-1:0] col);
        return AW'(row) * AW'(MAX_PAIRS) + AW'(col);
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr.pref_we)
        begin
            pref_mem[flat_addr(wr.person, wr.rank_pos)] <= wr.partner;
        end
        if (wr.rank_we)
        begin
            rank_mem[flat_addr(wr.person, wr.partner)] <= wr.rank_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        rdat_reg.pref_acc <= pref_mem[flat_addr(rd.pref_prop, rd.pref_pos)];
        rdat_reg.rank_new <= rank_mem[flat_addr(rd.rank_acc, rd.rank_new)];
        rdat_reg.rank_cur <= rank_mem[flat_addr(rd.rank_acc, rd.rank_cur)];
    end

    assign rdat = rdat_reg;

endmodule

`default_nettype wire

>>> dv/stable_matching_engine_unit_checker.sv
// Checker that tracks the request and result channels, predicts each matching run and checks every pair.
`timescale 1ns / 100ps

module stable_matching_engine_unit_checker
    import sme_pkg::*;
#(
    parameter int MAX_PAIRS = 32
)(
    input  logic               clk,
    input  logic               rst_n,
    sme_req_if                 req,
    sme_res_if                 res,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    output int                 fail_count,
    output int                 pending
);

    localparam int UNMATCHED   = -1;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [PERSON_W-1:0] proposer;
        logic [PERSON_W-1:0] acceptor;
        logic                last_pair;
    } pair_t;

    logic [PERSON_W-1:0] pref_tab [MAX_PAIRS][MAX_PAIRS];
    logic [PERSON_W-1:0] rank_tab [MAX_PAIRS][MAX_PAIRS];
    logic [COUNT_W-1:0]  pair_count_q;
    int                  free_stack [MAX_PAIRS];
    int                  stack_depth;
    int                  mismatches;
    pair_t               expected_pairs [$];

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
        begin
            $display("[%0t] pair mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic void push_free(input int p);
        if (stack_depth < MAX_PAIRS)
        begin
            free_stack[stack_depth] = p;
            stack_depth++;
        end
    endfunction

    function automatic int pairs_in_use();
        int cap;
        int n;
        cap = (MAX_PAIRS < 32) ? MAX_PAIRS : 32;
        n = int'(pair_count_q);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > cap)
        begin
            n = cap;
        end
        return n;
    endfunction

    function automatic void solve_matching(input int n);
        int    next_pos [MAX_PAIRS];
        int    acc_mate [MAX_PAIRS];
        int    prop_mate [MAX_PAIRS];
        int    i;
        int    m;
        int    w;
        int    cur;
        pair_t pr;
        stack_depth = 0;
        for (i = 0; i < MAX_PAIRS; i++)
        begin
            next_pos[i]  = 0;
            acc_mate[i]  = UNMATCHED;
            prop_mate[i] = 0;
        end
        for (i = 0; i < n; i++)
        begin
            push_free(i);
        end
        while (stack_depth != 0)
        begin
            stack_depth--;
            m = free_stack[stack_depth];
            if (m < n && next_pos[m] < n)
            begin
                w = int'(pref_tab[m][next_pos[m]]);
                next_pos[m]++;
                if (w >= n)
                begin
                    push_free(m);
                end
                else
                begin
                    cur = acc_mate[w];
                    if (cur == UNMATCHED)
                    begin
                        acc_mate[w]  = m;
                        prop_mate[m] = w;
                    end
                    else if (rank_tab[w][m] < rank_tab[w][cur])
                    begin
                        prop_mate[cur] = 0;
                        push_free(cur);
                        acc_mate[w]  = m;
                        prop_mate[m] = w;
                    end
                    else
                    begin
                        push_free(m);
                    end
                end
            end
        end
        for (i = 0; i < n; i++)
        begin
            pr.proposer  = PERSON_W'(i);
            pr.acceptor  = PERSON_W'(prop_mate[i]);
            pr.last_pair = (i == n - 1);
            expected_pairs.push_back(pr);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pair_t got;
        pair_t want;
        if (!rst_n)
        begin
            pair_count_q = PAIR_COUNT_RST;
            stack_depth  = 0;
            mismatches   = 0;
            expected_pairs.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                pair_count_q = cfg_wdata;
            end
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_LOAD_PROP)
                begin
                    if (req.person < MAX_PAIRS && req.rank_pos < MAX_PAIRS
                        && req.partner < MAX_PAIRS)
                    begin
                        pref_tab[req.person][req.rank_pos] = req.partner;
                    end
                end
                else if (req.req_type == REQ_LOAD_ACC)
                begin
                    if (req.person < MAX_PAIRS && req.rank_pos < MAX_PAIRS
                        && req.partner < MAX_PAIRS)
                    begin
                        rank_tab[req.person][req.partner] = req.rank_pos;
                    end
                end
                else if (req.req_type == REQ_RUN)
                begin
                    solve_matching(pairs_in_use());
                end
            end
            if (res.valid && res.ready)
            begin
                got = {res.proposer, res.acceptor, res.last_pair};
                if (expected_pairs.size() == 0)
                begin
                    report_mismatch($sformatf("pair %0d/%0d arrived with none expected",
                                              got.proposer, got.acceptor));
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (got.proposer !== want.proposer)
                    begin
                        report_mismatch($sformatf("proposer %0d, expected %0d",
                                                  got.proposer, want.proposer));
                    end
                    if (got.acceptor !== want.acceptor)
                    begin
                        report_mismatch($sformatf("proposer %0d got acceptor %0d, expected %0d",
                                                  want.proposer, got.acceptor, want.acceptor));
                    end
                    if (got.last_pair !== want.last_pair)
                    begin
                        report_mismatch($sformatf("proposer %0d last flag %0b, expected %0b",
                                                  want.proposer, got.last_pair, want.last_pair));
                    end
                end
            end
            pending    <= expected_pairs.size();
            fail_count <= mismatches;
        end
    end

endmodule

>>> dv/stable_matching_engine_unit_test.sv
// Top level of the stable matching engine testbench: stimulus, result-side flow control and verdict.
`timescale 1ns / 100ps

module stable_matching_engine_unit_test;
    import sme_pkg::*;

    localparam int                PAIRS         = 32;
    localparam logic [TYPE_W-1:0] REQ_UNUSED    = 2'd3;
    localparam int                RANDOM_ITEMS  = 400;
    localparam int                HOLD_CYCLES   = 400;
    localparam int                SETTLE_CYCLES = 4;
    localparam int                CYCLE_LIMIT   = 400000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    logic               long_hold;
    bit                 tx_quiet;
    int                 cur_n;
    int                 sent_items;
    int                 fail_count;
    int                 pending;

    sme_req_if req_ch ();
    sme_res_if res_ch ();

    stable_matching_engine_unit #(
        .MAX_PAIRS (PAIRS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    stable_matching_engine_unit_checker #(
        .MAX_PAIRS (PAIRS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [PERSON_W-1:0] any_index();
        return PERSON_W'($urandom_range(0, 31));
    endfunction

    task automatic send_item(input logic [TYPE_W-1:0] kind, input logic [PERSON_W-1:0] who,
                             input logic [PERSON_W-1:0] pos, input logic [PERSON_W-1:0] other);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.person   <= who;
        req_ch.rank_pos <= pos;
        req_ch.partner  <= other;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        if (kind != REQ_UNUSED)
        begin
            sent_items++;
        end
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pair_count(input logic [COUNT_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (value == 0)
        begin
            cur_n = 1;
        end
        else if (value > PAIRS)
        begin
            cur_n = PAIRS;
        end
        else
        begin
            cur_n = int'(value);
        end
    endtask

    // A shuffled list for one person; a noisy list also gets random entries, which give
    // duplicates, acceptors beyond the pair count and tied ranks.
    task automatic load_list(input logic [TYPE_W-1:0] kind, input int who, input int n,
                             input bit noisy);
        int order [PAIRS];
        int j;
        int k;
        int t;
        int v;
        for (k = 0; k < n; k++)
        begin
            order[k] = k;
        end
        for (k = n - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (k = 0; k < n; k++)
        begin
            v = order[k];
            if (noisy && $urandom_range(0, 3) == 0)
            begin
                v = $urandom_range(0, 31);
            end
            if (kind == REQ_LOAD_PROP)
            begin
                send_item(REQ_LOAD_PROP, PERSON_W'(who), PERSON_W'(k), PERSON_W'(v));
            end
            else
            begin
                send_item(REQ_LOAD_ACC, PERSON_W'(who), PERSON_W'(v), PERSON_W'(k));
            end
        end
    endtask

    // Every proposer gets a distinct first choice, so a full-size run settles on first
    // proposals alone and reads nothing past the first entry of a list.
    task automatic load_first_choices();
        int order [PAIRS];
        int j;
        int k;
        int t;
        for (k = 0; k < PAIRS; k++)
        begin
            order[k] = k;
        end
        for (k = PAIRS - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (k = 0; k < PAIRS; k++)
        begin
            send_item(REQ_LOAD_PROP, PERSON_W'(k), PERSON_W'(0), PERSON_W'(order[k]));
        end
    endtask

    task automatic load_all(input int n, input bit noisy);
        int p;
        for (p = 0; p < n; p++)
        begin
            load_list(REQ_LOAD_PROP, p, n, noisy);
            load_list(REQ_LOAD_ACC, p, n, noisy);
        end
    endtask

    task automatic run_match();
        send_item(REQ_RUN, any_index(), any_index(), any_index());
    endtask

    task automatic send_noise();
        if ($urandom_range(0, 2) == 0)
        begin
            send_item(REQ_UNUSED, any_index(), any_index(), any_index());
        end
        else
        begin
            send_item($urandom_range(0, 1) ? REQ_LOAD_PROP : REQ_LOAD_ACC,
                      any_index(), any_index(), any_index());
        end
    endtask

    initial
    begin : result_side
        int rx_wait;
        bit rx_quiet;
        bit hold_done;
        rx_wait      = 0;
        rx_quiet     = 1'b0;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    rx_quiet = !rx_quiet;
                end
                if (long_hold && !hold_done)
                begin
                    rx_wait   = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
                else
                begin
                    rx_wait = rx_quiet ? 0 : $urandom_range(0, 5);
                end
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
            end
            res_ch.ready <= (rx_wait == 0);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("stable_matching_engine_unit_test failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int  rand_base;
        int  phase;
        int  rounds;
        int  pick;
        bit  noisy;
        logic [COUNT_W-1:0] cfg_val;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        long_hold       = 1'b0;
        tx_quiet        = 1'b0;
        cur_n           = PAIRS;
        sent_items      = 0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_LOAD_PROP;
        req_ch.person   = '0;
        req_ch.rank_pos = '0;
        req_ch.partner  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_first_choices();
        send_item(REQ_LOAD_PROP, 5'd31, 5'd31, 5'd31);
        send_item(REQ_LOAD_ACC, 5'd31, 5'd31, 5'd31);
        send_item(REQ_UNUSED, 5'd31, 5'd31, 5'd31);
        run_match();

        set_pair_count(6'd1);
        run_match();
        set_pair_count(6'd0);
        run_match();

        // Two pairs: the first run swaps an engaged acceptor, the second hits a rejection,
        // an acceptor beyond the pair count and an exhausted list, the third a tie in rank.
        set_pair_count(6'd2);
        send_item(REQ_LOAD_PROP, 5'd0, 5'd0, 5'd0);
        send_item(REQ_LOAD_PROP, 5'd0, 5'd1, 5'd7);
        send_item(REQ_LOAD_PROP, 5'd1, 5'd0, 5'd0);
        send_item(REQ_LOAD_PROP, 5'd1, 5'd1, 5'd1);
        send_item(REQ_LOAD_ACC, 5'd0, 5'd0, 5'd0);
        send_item(REQ_LOAD_ACC, 5'd0, 5'd1, 5'd1);
        send_item(REQ_LOAD_ACC, 5'd1, 5'd0, 5'd0);
        send_item(REQ_LOAD_ACC, 5'd1, 5'd0, 5'd1);
        run_match();
        send_item(REQ_LOAD_ACC, 5'd0, 5'd1, 5'd0);
        send_item(REQ_LOAD_ACC, 5'd0, 5'd0, 5'd1);
        run_match();
        send_item(REQ_LOAD_ACC, 5'd0, 5'd0, 5'd0);
        run_match();

        set_pair_count(6'd63);
        load_first_choices();
        run_match();
        set_pair_count(6'd33);
        run_match();

        rand_base = sent_items;
        phase = 0;
        while (sent_items - rand_base < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                cfg_val = $urandom_range(0, 1) ? COUNT_W'(0) : COUNT_W'($urandom_range(33, 63));
            end
            else if (pick == 1)
            begin
                cfg_val = COUNT_W'($urandom_range(9, 12));
            end
            else
            begin
                cfg_val = COUNT_W'($urandom_range(1, 8));
            end
            set_pair_count(cfg_val);
            tx_quiet = ($urandom_range(0, 3) == 0);
            noisy    = ($urandom_range(0, 2) == 0);
            if (cur_n <= 16)
            begin
                load_all(cur_n, noisy);
            end
            rounds = $urandom_range(2, 4);
            repeat (rounds)
            begin
                repeat ($urandom_range(0, 3)) send_noise();
                if (cur_n > 16)
                begin
                    load_first_choices();
                end
                if (phase == 0)
                begin
                    long_hold <= 1'b1;
                end
                run_match();
                if (cur_n <= 16)
                begin
                    repeat ($urandom_range(1, 2))
                    begin
                        load_list($urandom_range(0, 1) ? REQ_LOAD_PROP : REQ_LOAD_ACC,
                                  $urandom_range(0, cur_n - 1), cur_n,
                                  $urandom_range(0, 3) == 0);
                    end
                end
            end
            phase++;
        end

        settle();
        if (fail_count == 0)
        begin
            $display("stable_matching_engine_unit_test passed");
        end
        else
        begin
            $display("stable_matching_engine_unit_test failed");
        end
        $finish;
    end

endmodule
